// ===== src/bis_pkg.sv =====
// package for the interpreter step block: sizes, codes and payload types
package bis_pkg;
    localparam int NUM_VARS     = 256;
    localparam int RETURN_DEPTH = 8;
    localparam int NUM_LABELS   = 256;
    localparam int NUM_VECTORS  = 16;
    localparam int VAR_AW = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
    localparam int LBL_AW = (NUM_LABELS > 1) ? $clog2(NUM_LABELS) : 1;
    localparam int VEC_AW = (NUM_VECTORS > 1) ? $clog2(NUM_VECTORS) : 1;

    localparam logic [1:0] CMD_EXEC  = 2'd0;
    localparam logic [1:0] CMD_LABEL = 2'd1;
    localparam logic [1:0] CMD_VEC   = 2'd2;
    localparam logic [1:0] CMD_IRQ   = 2'd3;

    localparam logic [4:0] OP_ASSIGN = 5'd0;
    localparam logic [4:0] OP_MOVE   = 5'd1;
    localparam logic [4:0] OP_ADD    = 5'd2;
    localparam logic [4:0] OP_SUB    = 5'd3;
    localparam logic [4:0] OP_MUL    = 5'd4;
    localparam logic [4:0] OP_DIV    = 5'd5;
    localparam logic [4:0] OP_INCR   = 5'd6;
    localparam logic [4:0] OP_DECR   = 5'd7;
    localparam logic [4:0] OP_INV    = 5'd8;
    localparam logic [4:0] OP_TOB    = 5'd9;
    localparam logic [4:0] OP_CMP    = 5'd10;
    localparam logic [4:0] OP_HIGH   = 5'd11;
    localparam logic [4:0] OP_LOW    = 5'd12;
    localparam logic [4:0] OP_JUMP   = 5'd13;
    localparam logic [4:0] OP_CMPJMP = 5'd14;
    localparam logic [4:0] OP_RET    = 5'd15;
    localparam logic [4:0] OP_DEBUG  = 5'd16;
    localparam logic [4:0] OP_ERROR  = 5'd17;
    localparam logic [4:0] OP_SETFN  = 5'd18;
    localparam logic [4:0] OP_CALLFN = 5'd19;
    localparam logic [4:0] OP_EXIT   = 5'd20;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_EXIT   = 3'd1;
    localparam logic [2:0] ST_BADOP  = 3'd2;
    localparam logic [2:0] ST_USRERR = 3'd3;
    localparam logic [2:0] ST_CALL   = 3'd4;
    localparam logic [2:0] ST_DEBUG  = 3'd5;

    localparam logic [7:0] BADOP_REPORT = 8'hB1;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [4:0]  op;
        logic        a_is_var;
        logic [7:0]  a_value;
        logic        b_is_var;
        logic [7:0]  b_value;
        logic        c_is_var;
        logic [7:0]  c_value;
        logic [7:0]  dest_var;
        logic        save_return;
        logic [15:0] next_pos;
        logic [15:0] table_value;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  status;
        logic        jump_taken;
        logic [15:0] new_pos;
        logic [7:0]  report_value;
        logic [7:0]  func_id;
    } t_out_word;
endpackage

// ===== src/bis_in_if.sv =====
// valid/ready channel for instruction words
interface bis_in_if;
    import bis_pkg::*;
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/bis_out_if.sv =====
// valid/ready channel for result words
interface bis_out_if;
    import bis_pkg::*;
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/bis_ram.sv =====
// generic single-port-write ram with registered read
module bis_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== src/bytecode_interpreter_step_top.sv =====
// top level of the interpreter step block
// usage:
//   i_in carries one instruction, table load or interrupt word; o_out returns
//   exactly one result word for each of them, in order.
//   the block handles one word at a time. a sequencer reads the variable file
//   (one read port, so operands a, b, dest and c go one after another), runs
//   the op and writes back. jumps, taken compare-jumps and interrupts also read
//   the label or vector table, and table loads write it. a division works out
//   eight quotient bits, one a cycle, then writes back.
//   a new word can be taken from the cycle after the result is registered.
//   reset: a clearing pass writes zero into every entry of the variable
//   file; no word is accepted until it ends. return stack and selected
//   function id reset at once.
//   the result sits in an output register and holds while the receiver
//   stalls; the next word is still taken and run, but its result waits in
//   the last step until the held one is taken.
module bytecode_interpreter_step_top (
    input  logic     i_clk,
    input  logic     i_rst_n,
    bis_in_if.sink   i_in,
    bis_out_if.source o_out
);
    import bis_pkg::*;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_RDA   = 4'd2;
    localparam logic [3:0] S_RDB   = 4'd3;
    localparam logic [3:0] S_RDD   = 4'd4;
    localparam logic [3:0] S_RDC   = 4'd5;
    localparam logic [3:0] S_EXEC  = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_TBL   = 4'd8;
    localparam logic [3:0] S_TBLW  = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [3:0]      r_state;
    t_in_word        r_w;
    logic [VAR_AW:0] r_clr;
    logic [7:0]      r_a, r_b, r_d, r_c;
    logic [7:0]      r_sel;
    logic [15:0]     r_stk [RETURN_DEPTH];
    logic [7:0]      r_quo;
    logic [8:0]      r_rem;
    logic [3:0]      r_dcnt;
    logic            r_tbl_lbl;
    logic            r_tbl_ok;
    t_out_word       r_res;
    t_out_word       r_out;
    logic            r_ovalid;

    // variable file ram ports
    logic              v_we;
    logic [VAR_AW-1:0] v_waddr, v_raddr;
    logic [7:0]        v_wdata, v_rdata;
    logic [7:0]        v_ridx;
    logic              r_rd_ok;

    logic [LBL_AW-1:0] l_addr;
    logic [15:0]       l_rdata;
    logic              l_we;
    logic [VEC_AW-1:0] vec_addr;
    logic [15:0]       vec_rdata;
    logic              vec_we;

    bis_ram #(.WIDTH(8), .DEPTH(NUM_VARS)) u_var (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(v_waddr), .i_wdata(v_wdata),
        .i_raddr(v_raddr), .o_rdata(v_rdata));
    bis_ram #(.WIDTH(16), .DEPTH(NUM_LABELS)) u_lbl (
        .i_clk(i_clk), .i_we(l_we), .i_waddr(l_addr), .i_wdata(r_w.table_value),
        .i_raddr(l_addr), .o_rdata(l_rdata));
    bis_ram #(.WIDTH(16), .DEPTH(NUM_VECTORS)) u_vec (
        .i_clk(i_clk), .i_we(vec_we), .i_waddr(vec_addr), .i_wdata(r_w.table_value),
        .i_raddr(vec_addr), .o_rdata(vec_rdata));

    // read value with out-of-range masking
    logic [7:0] rd_val;
    assign rd_val = r_rd_ok ? v_rdata : 8'd0;

    // read address selection per state
    always_comb begin
        unique case (r_state)
            S_RDA:   v_ridx = r_w.a_value;
            S_RDB:   v_ridx = r_w.b_value;
            S_RDD:   v_ridx = r_w.dest_var;
            default: v_ridx = r_w.c_value;
        endcase
    end
    assign v_raddr = v_ridx[VAR_AW-1:0];

    // exec-stage result value
    logic [7:0]  ex_val;
    logic        ex_wr;
    logic [15:0] prod;
    assign prod = 16'(r_a) * 16'(r_b);
    always_comb begin
        ex_wr  = 1'b1;
        ex_val = 8'd0;
        case (r_w.op)
            OP_ASSIGN: ex_val = r_w.a_value;
            OP_MOVE:   ex_val = r_c;
            OP_ADD:    ex_val = r_a + r_b;
            OP_SUB:    ex_val = r_a - r_b;
            OP_MUL:    ex_val = prod[7:0];
            OP_INCR:   ex_val = r_d + 8'd1;
            OP_DECR:   ex_val = r_d - 8'd1;
            OP_INV:    ex_val = {7'd0, r_d == 8'd0};
            OP_TOB:    ex_val = {7'd0, r_d != 8'd0};
            OP_CMP:    ex_val = {7'd0, r_a == r_b};
            OP_HIGH:   ex_val = {7'd0, r_a > r_b};
            OP_LOW:    ex_val = {7'd0, r_a < r_b};
            default:   ex_wr  = 1'b0;
        endcase
    end

    logic dest_ok;
    assign dest_ok = 9'(r_w.dest_var) < 9'(NUM_VARS);

    // clear pass or writeback
    always_comb begin
        v_we    = 1'b0;
        v_waddr = r_w.dest_var[VAR_AW-1:0];
        v_wdata = ex_val;
        if (r_state == S_CLEAR) begin
            v_we    = 1'b1;
            v_waddr = r_clr[VAR_AW-1:0];
            v_wdata = 8'd0;
        end else if (r_state == S_EXEC) begin
            v_we = ex_wr && dest_ok && (r_w.cmd == CMD_EXEC);
        end else if (r_state == S_DIV && r_dcnt == 4'd0) begin
            v_we    = dest_ok;
            v_wdata = (r_b == 8'd0) ? 8'hFF : r_quo;
        end
    end

    // table index: label from a, c, or load index; vector from a
    logic [7:0] lbl_idx;
    always_comb begin
        if (r_w.cmd == CMD_LABEL)       lbl_idx = r_w.a_value;
        else if (r_w.op == OP_CMPJMP)   lbl_idx = r_c;
        else                            lbl_idx = r_a;
    end
    assign l_addr = lbl_idx[LBL_AW-1:0];
    assign vec_addr = r_w.a_value[VEC_AW-1:0];
    assign l_we = (r_state == S_TBL) && (r_w.cmd == CMD_LABEL)
                  && (9'(r_w.a_value) < 9'(NUM_LABELS));
    assign vec_we = (r_state == S_TBL) && (r_w.cmd == CMD_VEC)
                    && (9'(r_w.a_value) < 9'(NUM_VECTORS));

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_out;

    logic push_now;
    assign push_now = (r_state == S_EXEC) && (
        (r_w.cmd == CMD_IRQ) ||
        (r_w.cmd == CMD_EXEC && r_w.save_return &&
         (r_w.op == OP_JUMP || r_w.op == OP_CMPJMP)));

    logic [8:0] div_try;
    assign div_try = {r_rem[7:0], r_a[3'(r_dcnt - 4'd1)]} - {1'b0, r_b};

    // sequencer
    always_ff @(posedge i_clk) begin
        r_rd_ok <= 9'(v_ridx) < 9'(NUM_VARS);
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_sel    <= 8'd0;
            r_ovalid <= 1'b0;
            for (int k = 0; k < RETURN_DEPTH; k++) r_stk[k] <= 16'd0;
        end else begin
            if (r_ovalid && o_out.ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (VAR_AW+1)'(NUM_VARS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_w     <= i_in.data;
                        r_state <= S_RDA;
                    end
                end
                S_RDA: r_state <= S_RDB;
                S_RDB: begin
                    r_a     <= r_w.a_is_var ? rd_val : r_w.a_value;
                    r_c     <= rd_val;
                    r_state <= S_RDD;
                end
                S_RDD: begin
                    r_b     <= r_w.b_is_var ? rd_val : r_w.b_value;
                    r_state <= S_RDC;
                end
                S_RDC: begin
                    r_d     <= rd_val;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    // r_c: move source (a var) or cmpjump label operand
                    if (r_w.op == OP_CMPJMP)
                        r_c <= r_w.c_is_var ? rd_val : r_w.c_value;
                    r_res <= '0;
                    r_tbl_lbl <= 1'b0;
                    r_tbl_ok  <= 1'b0;
                    if (push_now) begin
                        for (int k = RETURN_DEPTH - 1; k > 0; k--) r_stk[k] <= r_stk[k-1];
                        r_stk[0] <= r_w.next_pos;
                    end
                    r_state <= S_OUT;
                    unique case (r_w.cmd)
                        CMD_LABEL, CMD_VEC: r_state <= S_TBL;
                        CMD_IRQ: begin
                            r_res.jump_taken <= 1'b1;
                            r_tbl_ok <= 9'(r_w.a_value) < 9'(NUM_VECTORS);
                            r_state  <= S_TBL;
                        end
                        default: begin
                            case (r_w.op)
                                OP_DIV: begin
                                    r_quo <= 8'd0; r_rem <= 9'd0; r_dcnt <= 4'd8;
                                    r_state <= S_DIV;
                                end
                                OP_JUMP: begin
                                    r_res.jump_taken <= 1'b1;
                                    r_tbl_lbl <= 1'b1;
                                    r_tbl_ok <= 9'(r_a) < 9'(NUM_LABELS);
                                    r_state <= S_TBL;
                                end
                                OP_CMPJMP: begin
                                    if (r_a == r_b) begin
                                        r_res.jump_taken <= 1'b1;
                                        r_tbl_lbl <= 1'b1;
                                        r_state <= S_TBL;
                                    end
                                end
                                OP_RET: begin
                                    r_res.jump_taken <= 1'b1;
                                    r_res.new_pos <= r_stk[0];
                                    for (int k = 1; k < RETURN_DEPTH; k++) r_stk[k-1] <= r_stk[k];
                                end
                                OP_DEBUG: begin
                                    r_res.status <= ST_DEBUG; r_res.report_value <= r_a;
                                end
                                OP_ERROR: begin
                                    r_res.status <= ST_USRERR; r_res.report_value <= r_a;
                                end
                                OP_SETFN:  r_sel <= r_a;
                                OP_CALLFN: begin
                                    r_res.status <= ST_CALL; r_res.func_id <= r_sel;
                                end
                                OP_EXIT: r_res.status <= ST_EXIT;
                                default: begin
                                    if (r_w.op > OP_EXIT) begin
                                        r_res.status <= ST_BADOP;
                                        r_res.report_value <= BADOP_REPORT;
                                    end
                                end
                            endcase
                        end
                    endcase
                end
                S_DIV: begin
                    // restoring division, one quotient bit a cycle
                    if (r_dcnt == 4'd0) begin
                        r_state <= S_OUT;
                    end else begin
                        if (!div_try[8]) begin
                            r_rem <= div_try;
                            r_quo <= {r_quo[6:0], 1'b1};
                        end else begin
                            r_rem <= {r_rem[7:0], r_a[3'(r_dcnt - 4'd1)]};
                            r_quo <= {r_quo[6:0], 1'b0};
                        end
                        r_dcnt <= r_dcnt - 4'd1;
                    end
                end
                S_TBL: begin
                    if (r_w.op == OP_CMPJMP && r_w.cmd == CMD_EXEC)
                        r_tbl_ok <= 9'(r_c) < 9'(NUM_LABELS);
                    r_state <= S_TBLW;
                end
                S_TBLW: begin
                    if (r_res.jump_taken)
                        r_res.new_pos <= !r_tbl_ok ? 16'd0 :
                                         (r_tbl_lbl ? l_rdata : vec_rdata);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // hand the result to the output register once it is free
                    if (!r_ovalid || o_out.ready) begin
                        r_out    <= r_res;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== src/bis_checker.sv =====
// port-level checker for the interpreter step block, bound to the top level
module bis_port_props (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input bis_pkg::t_out_word out_data
);
    import bis_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // no new word taken the cycle after one was taken
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("two words accepted back to back");

    // no jump means position zero
    a_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_data.jump_taken |-> out_data.new_pos == 16'd0)
        else $error("position without jump");

    // status stays in its code range
    a_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> out_data.status <= ST_DEBUG)
        else $error("bad status code");
endmodule

bind bytecode_interpreter_step_top bis_port_props u_bis_port_props (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(i_in.valid), .in_ready(i_in.ready),
    .out_valid(o_out.valid), .out_ready(o_out.ready), .out_data(o_out.data));
